/* rtl/sdlc_pkg.sv */
// sdlc_pkg: shared types, sizes and key packing for the sampler descriptor lru cache
// no dependencies; used by the interfaces and the top level
`default_nettype none

package sdlc_pkg;

    // table size and derived widths
    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LEAVES  = 1 << IDX_W;
    localparam int KEY_W   = 23;
    localparam int CFG_W   = 7;
    localparam int SLOT_W  = 6;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [ENTRIES-1:0] mask_t;
    typedef logic [CFG_W-1:0]   cfg_t;

    localparam cfg_t CFG_RESET   = CFG_W'(64);
    localparam idx_t RANK_MAX    = IDX_W'(ENTRIES - 1);
    localparam logic [1:0] TAG_NORMAL  = 2'b01;
    localparam logic [1:0] TAG_STRIDED = 2'b11;

    // entries taking part: zero acts as one, above the table size acts as the table size
    function automatic mask_t active_mask(input cfg_t cfg);
        int    n;
        mask_t m;
        n = int'(cfg);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > ENTRIES)
        begin
            n = ENTRIES;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            m[i] = (i < n);
        end
        return m;
    endfunction

    // pack one descriptor into its lookup key
    function automatic key_t pack_key(
        input logic       strided,
        input logic [2:0] v_mode,
        input logic [2:0] u_mode,
        input logic       mip,
        input logic [1:0] min_f,
        input logic [1:0] mag_f,
        input logic [5:0] bias,
        input logic [1:0] lod_lo,
        input logic [1:0] lod_hi
    );
        key_t k;
        if (strided)
        begin
            k = KEY_W'({mag_f, u_mode, v_mode, TAG_STRIDED});
        end
        else
        begin
            k = {lod_hi, lod_lo, bias, mag_f, min_f, mip, u_mode, v_mode, TAG_NORMAL};
        end
        return k;
    endfunction

endpackage

`default_nettype wire

/* rtl/sdlc_ifs.sv */
// sdlc_ifs: channel interfaces for descriptor words, slot result words and config writes
// depends on sdlc_pkg for the register width
`default_nettype none

interface sdlc_desc_if;
    logic       valid;
    logic       ready;
    logic       is_strided;
    logic [2:0] v_address_mode;
    logic [2:0] u_address_mode;
    logic       mip_filter_mode;
    logic [1:0] minify_filter;
    logic [1:0] magnify_filter;
    logic [5:0] lod_bias_value;
    logic [1:0] lod_min_low;
    logic [1:0] lod_min_high;

    modport source (
        output valid, is_strided, v_address_mode, u_address_mode, mip_filter_mode,
               minify_filter, magnify_filter, lod_bias_value, lod_min_low, lod_min_high,
        input  ready
    );
    modport sink (
        input  valid, is_strided, v_address_mode, u_address_mode, mip_filter_mode,
               minify_filter, magnify_filter, lod_bias_value, lod_min_low, lod_min_high,
        output ready
    );
endinterface

interface sdlc_slot_if;
    logic       valid;
    logic       ready;
    logic [5:0] sampler_slot;
    logic       newly_allocated;

    modport source (output valid, sampler_slot, newly_allocated, input ready);
    modport sink (input valid, sampler_slot, newly_allocated, output ready);
endinterface

interface sdlc_cfg_if;
    logic                 valid;
    logic                 ready;
    sdlc_pkg::cfg_t       entries_in_use;

    modport source (output valid, entries_in_use, input ready);
    modport sink (input valid, entries_in_use, output ready);
endinterface

`default_nettype wire

/* rtl/sampler_descriptor_lru_cache.sv */
// sampler_descriptor_lru_cache: fully associative sampler key table with true lru replacement
// depends on sdlc_pkg and the channel interfaces in sdlc_ifs.sv
//
// usage:
//   desc   - descriptor words in; each word is packed into a 23-bit key
//   result - one word out per descriptor: sampler_slot and newly_allocated
//            (newly_allocated = 1 means the slot was replaced and needs setup)
//   cfg    - entries_in_use write; always ready, write only while no word is in flight
// path: a descriptor accepted lands in the input register, and its result is registered
//   in the result register once that register is empty or its word is being taken
// throughput: one word per cycle while result words are taken; the path from the input
//   register to the result register is the parallel key compare, a 6-level min-rank
//   tree and the rank update
// reset: all keys clear to empty, ranks return to entry order (entry 0 least recent),
//   entries_in_use returns to 64; no clearing sweep, the block is ready at once
// stall: while the result word waits, the input register still takes one more word;
//   after that desc.ready drops until the result is taken
`default_nettype none

module sampler_descriptor_lru_cache (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sdlc_desc_if.sink   desc,
    sdlc_slot_if.source result,
    sdlc_cfg_if.sink    cfg
);

    // table state
    sdlc_pkg::key_t  key_reg  [sdlc_pkg::ENTRIES];
    sdlc_pkg::idx_t  rank_reg [sdlc_pkg::ENTRIES];
    sdlc_pkg::mask_t active_mask_reg;

    // input register
    logic           s1_valid_reg;
    sdlc_pkg::key_t s1_key_reg;

    // result register
    logic           res_valid_reg;
    sdlc_pkg::idx_t res_slot_reg;
    logic           res_new_reg;

    // lookup logic
    sdlc_pkg::mask_t hit_vec;
    sdlc_pkg::mask_t hit_low;
    sdlc_pkg::mask_t sel_vec;
    logic            any_hit;
    sdlc_pkg::idx_t  hit_idx;
    sdlc_pkg::idx_t  lru_idx;
    sdlc_pkg::idx_t  slot_idx;
    sdlc_pkg::idx_t  old_rank;
    sdlc_pkg::idx_t  rank_next [sdlc_pkg::ENTRIES];

    // min-rank tree, heap order: node 1 is the root, leaves from LEAVES up
    logic           node_vld  [2*sdlc_pkg::LEAVES];
    sdlc_pkg::idx_t node_rank [2*sdlc_pkg::LEAVES];
    sdlc_pkg::idx_t node_idx  [2*sdlc_pkg::LEAVES];

    logic s1_move;
    logic desc_take;

    assign s1_move   = s1_valid_reg && (!res_valid_reg || result.ready);
    assign desc.ready = !s1_valid_reg || s1_move;
    assign desc_take = desc.valid && desc.ready;
    assign cfg.ready = 1'b1;

    assign result.valid           = res_valid_reg;
    assign result.sampler_slot    = sdlc_pkg::SLOT_W'(res_slot_reg);
    assign result.newly_allocated = res_new_reg;

    // parallel key compare, lowest matching entry wins
    always_comb
    begin
        for (int i = 0; i < sdlc_pkg::ENTRIES; i++)
        begin
            hit_vec[i] = active_mask_reg[i] && (key_reg[i] == s1_key_reg);
        end
        hit_low = hit_vec & (~hit_vec + sdlc_pkg::mask_t'(1));
        any_hit = |hit_vec;
        hit_idx = '0;
        for (int i = 0; i < sdlc_pkg::ENTRIES; i++)
        begin
            if (hit_low[i])
            begin
                hit_idx = hit_idx | sdlc_pkg::IDX_W'(i);
            end
        end
    end

    // least recent active entry through a compare-select tree
    always_comb
    begin
        for (int k = 0; k < 2*sdlc_pkg::LEAVES; k++)
        begin
            node_vld[k]  = 1'b0;
            node_rank[k] = '0;
            node_idx[k]  = '0;
        end
        for (int k = 0; k < sdlc_pkg::LEAVES; k++)
        begin
            if (k < sdlc_pkg::ENTRIES)
            begin
                node_vld[sdlc_pkg::LEAVES+k]  = active_mask_reg[k];
                node_rank[sdlc_pkg::LEAVES+k] = rank_reg[k];
            end
            node_idx[sdlc_pkg::LEAVES+k] = sdlc_pkg::IDX_W'(k);
        end
        for (int k = sdlc_pkg::LEAVES - 1; k >= 1; k--)
        begin
            if (node_vld[2*k] && (!node_vld[2*k+1] || node_rank[2*k] < node_rank[2*k+1]))
            begin
                node_vld[k]  = 1'b1;
                node_rank[k] = node_rank[2*k];
                node_idx[k]  = node_idx[2*k];
            end
            else
            begin
                node_vld[k]  = node_vld[2*k+1];
                node_rank[k] = node_rank[2*k+1];
                node_idx[k]  = node_idx[2*k+1];
            end
        end
        lru_idx = node_idx[1];
    end

    // chosen slot, its old rank and the new ranks
    always_comb
    begin
        slot_idx = any_hit ? hit_idx : lru_idx;
        old_rank = '0;
        for (int i = 0; i < sdlc_pkg::ENTRIES; i++)
        begin
            sel_vec[i] = (sdlc_pkg::IDX_W'(i) == slot_idx);
            if (sel_vec[i])
            begin
                old_rank = old_rank | rank_reg[i];
            end
        end
        for (int i = 0; i < sdlc_pkg::ENTRIES; i++)
        begin
            if (sel_vec[i])
            begin
                rank_next[i] = sdlc_pkg::RANK_MAX;
            end
            else if (rank_reg[i] > old_rank)
            begin
                rank_next[i] = rank_reg[i] - 1'b1;
            end
            else
            begin
                rank_next[i] = rank_reg[i];
            end
        end
    end

    // table state and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sdlc_pkg::ENTRIES; i++)
            begin
                key_reg[i]  <= '0;
                rank_reg[i] <= sdlc_pkg::IDX_W'(i);
            end
            active_mask_reg <= sdlc_pkg::active_mask(sdlc_pkg::CFG_RESET);
        end
        else
        begin
            if (cfg.valid)
            begin
                active_mask_reg <= sdlc_pkg::active_mask(cfg.entries_in_use);
            end
            if (s1_move)
            begin
                for (int i = 0; i < sdlc_pkg::ENTRIES; i++)
                begin
                    rank_reg[i] <= rank_next[i];
                    if (sel_vec[i] && !any_hit)
                    begin
                        key_reg[i] <= s1_key_reg;
                    end
                end
            end
        end
    end

    // handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (desc.ready)
            begin
                s1_valid_reg <= desc.valid;
            end
            if (s1_move)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (desc_take)
        begin
            s1_key_reg <= sdlc_pkg::pack_key(desc.is_strided, desc.v_address_mode,
                desc.u_address_mode, desc.mip_filter_mode, desc.minify_filter,
                desc.magnify_filter, desc.lod_bias_value, desc.lod_min_low,
                desc.lod_min_high);
        end
        if (s1_move)
        begin
            res_slot_reg <= slot_idx;
            res_new_reg  <= !any_hit;
        end
    end

    // the returned slot is always one of the entries in use
    a_slot_active: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> active_mask_reg[res_slot_reg])
        else $error("result slot outside the entries in use");

    // the returned slot becomes most recent
    a_slot_mru: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> rank_reg[res_slot_reg] == sdlc_pkg::RANK_MAX)
        else $error("returned slot not most recent");

    // the returned slot holds the looked-up key
    a_slot_key: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> key_reg[res_slot_reg] == $past(s1_key_reg))
        else $error("returned slot does not hold the key");

    // entry zero always takes part
    a_entry0_active: assert property (@(posedge clk) disable iff (!rst_n)
        active_mask_reg[0])
        else $error("no entry in use");

endmodule

`default_nettype wire

/* dv/sampler_descriptor_lru_cache_tb.sv */
// testbench for sampler_descriptor_lru_cache: descriptor words in, slot binding words out
// predicts every binding with its own lru table model and checks each result word
// depends on sdlc_pkg and the channel interfaces in rtl/sdlc_ifs.sv

// one descriptor word as driven on the input channel
typedef struct packed {
    logic       is_strided;
    logic [2:0] v_address_mode;
    logic [2:0] u_address_mode;
    logic       mip_filter_mode;
    logic [1:0] minify_filter;
    logic [1:0] magnify_filter;
    logic [5:0] lod_bias_value;
    logic [1:0] lod_min_low;
    logic [1:0] lod_min_high;
} desc_word_t;

// one expected slot binding
typedef struct {
    logic [5:0] slot;
    logic       alloc;
} binding_t;

// lru table model plus the queue of bindings still owed by the block
class sampler_binding_tracker;
    logic [22:0]  key_table [sdlc_pkg::ENTRIES];
    int unsigned  rank_table [sdlc_pkg::ENTRIES];
    logic [6:0]   entries_cfg;
    binding_t     owed [$];
    int unsigned  failures;
    int unsigned  hits;
    int unsigned  allocs;
    int unsigned  words_in;

    function new();
        for (int i = 0; i < sdlc_pkg::ENTRIES; i++)
        begin
            key_table[i]  = '0;
            rank_table[i] = i;
        end
        entries_cfg = sdlc_pkg::CFG_RESET;
        failures    = 0;
        hits        = 0;
        allocs      = 0;
        words_in    = 0;
    endfunction

    // key layout differs between strided and normal descriptors
    function logic [22:0] descriptor_key(input desc_word_t d);
        logic [22:0] k;
        k = '0;
        k[4:2] = d.v_address_mode;
        k[7:5] = d.u_address_mode;
        if (d.is_strided)
        begin
            k[1:0] = sdlc_pkg::TAG_STRIDED;
            k[9:8] = d.magnify_filter;
        end
        else
        begin
            k[1:0]   = sdlc_pkg::TAG_NORMAL;
            k[8]     = d.mip_filter_mode;
            k[10:9]  = d.minify_filter;
            k[12:11] = d.magnify_filter;
            k[18:13] = d.lod_bias_value;
            k[20:19] = d.lod_min_low;
            k[22:21] = d.lod_min_high;
        end
        return k;
    endfunction

    // lookup, replace on miss, promote to most recent, queue the binding
    function void note_descriptor(input desc_word_t d);
        logic [22:0] key;
        int unsigned n;
        int unsigned slot;
        int unsigned low_rank;
        int unsigned old_rank;
        bit          found;
        binding_t    b;
        key = descriptor_key(d);
        n = entries_cfg;
        if (n == 0)
        begin
            n = 1;
        end
        if (n > sdlc_pkg::ENTRIES)
        begin
            n = sdlc_pkg::ENTRIES;
        end
        found = 1'b0;
        slot  = 0;
        // lowest matching index wins, empty entries never match
        for (int i = 0; i < n; i++)
        begin
            if (!found && key_table[i] != '0 && key_table[i] == key)
            begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (!found)
        begin
            low_rank = sdlc_pkg::ENTRIES;
            for (int i = 0; i < n; i++)
            begin
                if (rank_table[i] < low_rank)
                begin
                    low_rank = rank_table[i];
                    slot     = i;
                end
            end
            key_table[slot] = key;
            allocs++;
        end
        else
        begin
            hits++;
        end
        // ranks above the promoted entry slide down by one, all entries included
        old_rank = rank_table[slot];
        for (int i = 0; i < sdlc_pkg::ENTRIES; i++)
        begin
            if (rank_table[i] > old_rank)
            begin
                rank_table[i]--;
            end
        end
        rank_table[slot] = sdlc_pkg::ENTRIES - 1;
        b.slot  = slot[5:0];
        b.alloc = !found;
        owed.push_back(b);
        words_in++;
    endfunction

    // compare one result word against the oldest owed binding
    function void check_binding(input logic [5:0] slot, input logic alloc);
        binding_t b;
        if (owed.size() == 0)
        begin
            $error("unexpected result word: sampler_slot %0d newly_allocated %0d", slot, alloc);
            failures++;
            return;
        end
        b = owed.pop_front();
        if (slot !== b.slot)
        begin
            $error("sampler_slot: expected %0d, actual %0d", b.slot, slot);
            failures++;
        end
        if (alloc !== b.alloc)
        begin
            $error("newly_allocated: expected %0d, actual %0d", b.alloc, alloc);
            failures++;
        end
    endfunction
endclass

module sampler_descriptor_lru_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES      = 16;
    localparam int RAND_WORDS  = 1950;
    localparam int POOL_DEPTH  = 96;
    localparam int STALL_LIMIT = 3000;

    logic clk = 1'b0;
    logic rst_n;

    sdlc_desc_if desc_ch ();
    sdlc_slot_if slot_ch ();
    sdlc_cfg_if  cfg_ch ();

    sampler_descriptor_lru_cache u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .desc   (desc_ch),
        .result (slot_ch),
        .cfg    (cfg_ch)
    );

    sampler_binding_tracker tracker = new();

    desc_word_t pool [POOL_DEPTH];
    int         burst_left;
    int         sender_mode;
    int         stall_mode;
    int         stall_hold;
    logic       stall_level;
    int unsigned stall_tick;
    int         idle_cycles;

    // clock: 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver ready pattern, changed per phase
    always @(negedge clk)
    begin
        stall_tick++;
        case (stall_mode)
            0: slot_ch.ready = 1'b1;
            1: slot_ch.ready = 1'($urandom_range(0, 1));
            2: slot_ch.ready = (stall_tick % 7) >= 3;
            default:
            begin
                if (stall_hold <= 0)
                begin
                    stall_hold  = $urandom_range(1, 30);
                    stall_level = ~stall_level;
                end
                stall_hold--;
                slot_ch.ready = stall_level;
            end
        endcase
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && slot_ch.valid && slot_ch.ready)
        begin
            tracker.check_binding(slot_ch.sampler_slot, slot_ch.newly_allocated);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((desc_ch.valid && desc_ch.ready) || (slot_ch.valid && slot_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic desc_word_t make_desc(input bit s, input int v, input int u,
                                             input int mip, input int mn, input int mag,
                                             input int bias, input int lo, input int hi);
        desc_word_t d;
        d.is_strided      = s;
        d.v_address_mode  = 3'(v);
        d.u_address_mode  = 3'(u);
        d.mip_filter_mode = 1'(mip);
        d.minify_filter   = 2'(mn);
        d.magnify_filter  = 2'(mag);
        d.lod_bias_value  = 6'(bias);
        d.lod_min_low     = 2'(lo);
        d.lod_min_high    = 2'(hi);
        return d;
    endfunction

    function automatic desc_word_t random_desc();
        return make_desc($urandom_range(0, 3) == 0, $urandom_range(0, 7), $urandom_range(0, 7),
                         $urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 3),
                         $urandom_range(0, 63), $urandom_range(0, 3), $urandom_range(0, 3));
    endfunction

    // mostly reuse a pool of descriptors so hits, evictions and duplicates happen
    function automatic desc_word_t next_desc(input int span);
        desc_word_t d;
        int         pick;
        int         r;
        r    = $urandom_range(0, 99);
        pick = $urandom_range(0, span - 1);
        if (r < 10)
        begin
            d = random_desc();
        end
        else
        begin
            if (r < 16)
            begin
                pool[pick] = random_desc();
            end
            d = pool[pick];
            // strided key ignores these fields, so vary them freely
            if (d.is_strided && $urandom_range(0, 1))
            begin
                d.mip_filter_mode = 1'($urandom_range(0, 1));
                d.minify_filter   = 2'($urandom_range(0, 3));
                d.lod_bias_value  = 6'($urandom_range(0, 63));
                d.lod_min_low     = 2'($urandom_range(0, 3));
                d.lod_min_high    = 2'($urandom_range(0, 3));
            end
        end
        return d;
    endfunction

    // send one descriptor word, with burst gaps set by the sender mode
    task automatic push_desc(input desc_word_t d);
        int gap;
        if (burst_left <= 0)
        begin
            case (sender_mode)
                0:
                begin
                    gap        = 0;
                    burst_left = 1000;
                end
                1:
                begin
                    gap        = $urandom_range(1, 4);
                    burst_left = $urandom_range(1, 8);
                end
                default:
                begin
                    gap        = $urandom_range(5, 40);
                    burst_left = $urandom_range(1, 3);
                end
            endcase
            repeat (gap)
            begin
                @(negedge clk);
                desc_ch.valid = 1'b0;
            end
        end
        @(negedge clk);
        desc_ch.valid           = 1'b1;
        desc_ch.is_strided      = d.is_strided;
        desc_ch.v_address_mode  = d.v_address_mode;
        desc_ch.u_address_mode  = d.u_address_mode;
        desc_ch.mip_filter_mode = d.mip_filter_mode;
        desc_ch.minify_filter   = d.minify_filter;
        desc_ch.magnify_filter  = d.magnify_filter;
        desc_ch.lod_bias_value  = d.lod_bias_value;
        desc_ch.lod_min_low     = d.lod_min_low;
        desc_ch.lod_min_high    = d.lod_min_high;
        do @(posedge clk); while (!desc_ch.ready);
        tracker.note_descriptor(d);
        burst_left--;
    endtask

    // stop sending and let every owed word come back
    task automatic drain();
        @(negedge clk);
        desc_ch.valid = 1'b0;
        burst_left    = 0;
        while (tracker.owed.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_entries(input logic [6:0] value);
        @(negedge clk);
        cfg_ch.valid          = 1'b1;
        cfg_ch.entries_in_use = value;
        do @(posedge clk); while (!cfg_ch.ready);
        tracker.entries_cfg = value;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // extremes of every field, strided and normal keys, hits and misses
    task automatic directed_words();
        push_desc(make_desc(0, 0, 0, 0, 0, 0, 0, 0, 0));
        push_desc(make_desc(0, 0, 0, 0, 0, 0, 0, 0, 0));
        push_desc(make_desc(0, 7, 7, 1, 3, 3, 63, 3, 3));
        push_desc(make_desc(1, 0, 0, 0, 0, 0, 0, 0, 0));
        push_desc(make_desc(1, 0, 0, 1, 3, 0, 63, 3, 3));
        push_desc(make_desc(1, 7, 7, 1, 3, 3, 63, 3, 3));
        push_desc(make_desc(1, 7, 7, 0, 0, 3, 0, 0, 0));
        push_desc(make_desc(0, 7, 0, 0, 0, 0, 0, 0, 0));
        push_desc(make_desc(0, 0, 7, 0, 0, 0, 0, 0, 0));
        push_desc(make_desc(0, 0, 0, 1, 0, 0, 0, 0, 0));
        push_desc(make_desc(0, 0, 0, 0, 3, 0, 0, 0, 0));
        push_desc(make_desc(0, 0, 0, 0, 0, 3, 0, 0, 0));
        push_desc(make_desc(0, 0, 0, 0, 0, 0, 63, 0, 0));
        push_desc(make_desc(0, 0, 0, 0, 0, 0, 0, 3, 0));
        push_desc(make_desc(0, 0, 0, 0, 0, 0, 0, 0, 3));
        push_desc(make_desc(0, 5, 2, 1, 2, 1, 42, 1, 2));
        push_desc(make_desc(0, 7, 7, 1, 3, 3, 63, 3, 3));
        push_desc(make_desc(1, 0, 0, 0, 0, 3, 0, 0, 0));
        push_desc(make_desc(0, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    initial
    begin
        logic [6:0] sizes [PHASES];
        int         active;
        int         span;
        int         per_phase;
        sizes = '{7'd1, 7'd4, 7'd64, 7'd0, 7'd2, 7'd127, 7'd65, 7'd3,
                  7'd17, 7'd64, 7'd8, 7'd33, 7'd1, 7'd64, 7'd100, 7'd12};
        per_phase = RAND_WORDS / PHASES;

        // all inputs known from time zero
        rst_n                   = 1'b0;
        desc_ch.valid           = 1'b0;
        desc_ch.is_strided      = 1'b0;
        desc_ch.v_address_mode  = '0;
        desc_ch.u_address_mode  = '0;
        desc_ch.mip_filter_mode = 1'b0;
        desc_ch.minify_filter   = '0;
        desc_ch.magnify_filter  = '0;
        desc_ch.lod_bias_value  = '0;
        desc_ch.lod_min_low     = '0;
        desc_ch.lod_min_high    = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.entries_in_use   = '0;
        slot_ch.ready           = 1'b0;
        burst_left  = 0;
        sender_mode = 0;
        stall_mode  = 0;
        stall_hold  = 0;
        stall_level = 1'b0;
        stall_tick  = 0;
        idle_cycles = 0;
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            pool[i] = random_desc();
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at the reset table size
        sender_mode = 1;
        stall_mode  = 1;
        directed_words();
        drain();

        // random phases, one table size each
        for (int p = 0; p < PHASES; p++)
        begin
            write_entries(sizes[p]);
            active = (sizes[p] == 0) ? 1 :
                     ((sizes[p] > sdlc_pkg::ENTRIES) ? sdlc_pkg::ENTRIES : int'(sizes[p]));
            span   = (active * 3 / 2 + 1 > POOL_DEPTH) ? POOL_DEPTH : active * 3 / 2 + 1;
            sender_mode = p % 3;
            stall_mode  = (p + 1) % 4;
            for (int k = 0; k < per_phase; k++)
            begin
                if ((p == 3 || p == 9) && k == per_phase / 2)
                begin
                    drain();
                end
                push_desc(next_desc(span));
            end
            drain();
        end

        if (tracker.owed.size() != 0)
        begin
            $error("%0d expected result words never arrived", tracker.owed.size());
            tracker.failures++;
        end
        $display("run covered %0d descriptor words: %0d hits, %0d new allocations",
                 tracker.words_in, tracker.hits, tracker.allocs);
        $display("over %0d table sizes from 0 to 127 with mixed sender gaps and result stalls",
                 PHASES);
        if (tracker.failures == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
